### hw/rtl/dfsr_pkg.sv
// ----------------------------------------------------------------------------
// dfsr_pkg
// widths, constants, word types and the restoring root step shared by the
// square root unit
// ----------------------------------------------------------------------------
package dfsr_pkg;

  // payload widths
  localparam int VALUE_W    = 32;
  localparam int INT_ROOT_W = 16;
  localparam int SCALED_W   = 33;

  // decimal places of the scaled root, clamped to the supported range
  localparam int FRACTION_DIGITS = 5;
  localparam int USED_DIGITS = (FRACTION_DIGITS > 6) ? 6 :
                               ((FRACTION_DIGITS < 0) ? 0 : FRACTION_DIGITS);

  // 10^(2d) = 5^(2d) * 2^(2d): odd factor by multiplier, the rest by shift
  localparam int unsigned FIVE_POW = 5 ** (2 * USED_DIGITS);
  localparam int ODD_W  = $clog2(FIVE_POW + 1);
  localparam int MAG_W  = VALUE_W - 1;
  localparam int PROD_W = MAG_W + ODD_W;

  // root bits produced by the cell row, one per cell
  localparam int ROOT_W    = 36;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int NUM_CELLS = ROOT_W;

  // one restoring root computation in flight
  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand bits not yet brought down
    logic [REM_W-1:0]  rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // partial root
  } dfsr_lane_t;

  // word handed from cell to cell
  typedef struct packed {
    logic       neg;
    dfsr_lane_t fine;   // root of value * 10^(2d)
    dfsr_lane_t whole;  // root of value
  } dfsr_word_t;

  // bring down two radicand bits, trial subtract, one root bit out
  function automatic dfsr_lane_t dfsr_step(input dfsr_lane_t a);
    dfsr_lane_t       r;
    logic [REM_W-1:0] part;
    logic [REM_W-1:0] trial;
    begin
      part  = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
      trial = REM_W'({a.root, 2'b01});
      r.rad = {a.rad[RAD_W-3:0], 2'b00};
      if (part >= trial) begin
        r.rem  = part - trial;
        r.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = part;
        r.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return r;
    end
  endfunction

endpackage

### hw/rtl/dfsr_in_if.sv
// ----------------------------------------------------------------------------
// dfsr_in_if
// operand channel: valid, ready and the signed value
// ----------------------------------------------------------------------------
interface dfsr_in_if
  import dfsr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### hw/rtl/dfsr_out_if.sv
// ----------------------------------------------------------------------------
// dfsr_out_if
// result channel: valid, ready and the two roots with the negative flag
// ----------------------------------------------------------------------------
interface dfsr_out_if
  import dfsr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [INT_ROOT_W-1:0] integer_root;
  logic [SCALED_W-1:0]   scaled_root;
  logic                  negative_input;

  modport source (output valid, output integer_root, output scaled_root,
                  output negative_input, input ready);
  modport sink   (input valid, input integer_root, input scaled_root,
                  input negative_input, output ready);
endinterface

### hw/rtl/dfsr_cell.sv
// ----------------------------------------------------------------------------
// dfsr_cell
// one stage of the root row: one restoring step on both lanes per word
// ----------------------------------------------------------------------------
module dfsr_cell
  import dfsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  input  dfsr_word_t up_word,
  input  logic       down_free,
  output logic       free,
  output logic       valid,
  output dfsr_word_t word
);

  // empty, or the word held here moves on this cycle
  assign free = !valid || down_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && up_valid) begin
      word.neg   <= up_word.neg;
      word.fine  <= dfsr_step(up_word.fine);
      word.whole <= dfsr_step(up_word.whole);
    end
  end

endmodule

### hw/rtl/decimal_fixed_point_square_root_unit.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_square_root_unit
// exact integer and decimal fixed point square root of a signed 32-bit word
// ----------------------------------------------------------------------------
// Takes a signed 32-bit word and returns floor(sqrt(value)) and the root
// truncated to five decimal places as an integer scaled by 100000, i.e.
// isqrt(value * 10^10), computed exactly with no rounding error. A negative
// value raises negative_input and both roots read zero. An accepted word
// first passes a load register, where the 31-bit magnitude is multiplied by
// the odd part of the decimal scale (5^10, the power of two is a shift), then
// walks a row of 36 identical cells, each producing one root bit of both the
// scaled and the plain root by restoring trial subtraction. Every word
// therefore passes 37 registers, the load register and then the cells in
// order; the row is a pipeline, so while the result side is ready a new word
// is taken each cycle and results leave at up to one per cycle. The last
// cell is the output register, and the stall ripples back only through
// full cells, so gaps in the row are closed while the
// result side waits. Scaled roots too wide for 33 bits, possible only with
// six decimal places, saturate to all ones.
// ----------------------------------------------------------------------------
module decimal_fixed_point_square_root_unit
  import dfsr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  dfsr_in_if.sink       operand,
  dfsr_out_if.source    result
);

  // load stage: magnitude times odd scale factor
  logic              load_valid;
  logic              load_free;
  logic              load_neg;
  logic [MAG_W-1:0]  load_mag;
  logic [PROD_W-1:0] load_prod;
  logic [MAG_W-1:0]  mag_in;

  // cell row, entry 0 is the load stage output
  logic       chain_valid [NUM_CELLS+1];
  dfsr_word_t chain_word  [NUM_CELLS+1];
  logic       chain_free  [NUM_CELLS+1];

  dfsr_word_t last_word;
  logic       scaled_wide;

  // negative words go down the row with a zero radicand
  assign mag_in = operand.value[VALUE_W-1] ? '0 : operand.value[MAG_W-1:0];

  assign load_free     = !load_valid || chain_free[1];
  assign operand.ready = load_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_valid <= 1'b0;
    end else if (load_free) begin
      load_valid <= operand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_free && operand.valid) begin
      load_neg  <= operand.value[VALUE_W-1];
      load_mag  <= mag_in;
      load_prod <= PROD_W'(mag_in) * PROD_W'(FIVE_POW);
    end
  end

  // word into the first cell: scaled radicand gets the power of two shift
  always_comb begin
    chain_word[0].neg        = load_neg;
    chain_word[0].fine.rad   = RAD_W'(load_prod) << (2 * USED_DIGITS);
    chain_word[0].fine.rem   = '0;
    chain_word[0].fine.root  = '0;
    chain_word[0].whole.rad  = RAD_W'(load_mag);
    chain_word[0].whole.rem  = '0;
    chain_word[0].whole.root = '0;
  end
  assign chain_valid[0] = load_valid;
  assign chain_free[0]  = load_free;

  // the row of root cells, one root bit each
  for (genvar i = 1; i <= NUM_CELLS; i++) begin : g_cell
    logic down_free;
    if (i == NUM_CELLS) begin : g_last
      assign down_free = result.ready;
    end else begin : g_mid
      assign down_free = chain_free[i+1];
    end

    dfsr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (chain_valid[i-1]),
      .up_word   (chain_word[i-1]),
      .down_free (down_free),
      .free      (chain_free[i]),
      .valid     (chain_valid[i]),
      .word      (chain_word[i])
    );
  end

  // last cell is the output register
  assign last_word   = chain_word[NUM_CELLS];
  assign scaled_wide = |last_word.fine.root[ROOT_W-1:SCALED_W];

  assign result.valid          = chain_valid[NUM_CELLS];
  assign result.integer_root   = last_word.whole.root[INT_ROOT_W-1:0];
  assign result.scaled_root    = scaled_wide ? '1 : last_word.fine.root[SCALED_W-1:0];
  assign result.negative_input = last_word.neg;

  // an accepted word always lands in the load register
  a_load_capture : assert property (@(posedge clk) disable iff (rst)
    operand.valid && operand.ready |=> load_valid)
    else $error("accepted word missing from load stage");

  // a load word blocked by a full first cell keeps its product
  a_load_hold : assert property (@(posedge clk) disable iff (rst)
    load_valid && !chain_free[1] |=> load_valid && $stable(load_prod))
    else $error("stalled load word changed");

  // negative input leaves zero roots at the output
  a_negative_zero : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.negative_input |->
      result.integer_root == '0 && result.scaled_root == '0)
    else $error("negative input gave a non-zero root");

  // the plain root never exceeds its 16-bit range
  a_whole_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> last_word.whole.root[ROOT_W-1:INT_ROOT_W] == '0)
    else $error("integer root out of range");

endmodule

### tb/tb_decimal_fixed_point_square_root_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_fixed_point_square_root_unit
// self-checking bench for the exact decimal fixed point square root unit
// ----------------------------------------------------------------------------
// Words are driven on the operand channel and every accepted word is run
// through a bit-serial square root predictor. Each word on the result channel
// is compared with the oldest prediction. Directed extremes come first, then
// random mixes under four idle and stall patterns, then a long receiver
// hold-off that fills the pipeline and stalls the operand side.
// ----------------------------------------------------------------------------
module tb_decimal_fixed_point_square_root_unit
  import dfsr_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 40;  // a little over the pipeline depth

  // one predicted result word
  typedef struct packed {
    logic [INT_ROOT_W-1:0] integer_root;
    logic [SCALED_W-1:0]   scaled_root;
    logic                  negative_input;
  } root_word_t;

  logic clk;
  logic rst;

  dfsr_in_if  operand ();
  dfsr_out_if result ();

  decimal_fixed_point_square_root_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .result  (result)
  );

  // predicted roots, oldest first
  root_word_t pending_roots[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int words_sent       = 0;
  int roots_checked    = 0;
  int mismatches       = 0;
  int input_stalls     = 0;
  int cycle_count      = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact roots by bit-serial search with wide products
  function automatic root_word_t predict_root(input logic signed [VALUE_W-1:0] v);
    root_word_t      w;
    logic [79:0]     mag;
    logic [79:0]     radicand;
    logic [79:0]     cand;
    logic [15:0]     whole;
    logic [35:0]     fine;
    int              k;
    begin
      w = '0;
      if (v < 0) begin
        w.negative_input = 1'b1;
      end else begin
        mag = 80'($unsigned(v));
        whole = '0;
        for (k = 15; k >= 0; k--) begin
          cand = 80'(whole) | (80'd1 << k);
          if (cand * cand <= mag) whole = cand[15:0];
        end
        // value * 10^(2d), at most about 2^71
        radicand = mag;
        for (k = 0; k < 2 * USED_DIGITS; k++) radicand = radicand * 80'd10;
        fine = '0;
        for (k = 35; k >= 0; k--) begin
          cand = 80'(fine) | (80'd1 << k);
          if (cand * cand <= radicand) fine = cand[35:0];
        end
        w.integer_root = whole;
        // too wide for the port only with six places: saturate
        w.scaled_root  = (fine > 36'h1FFFFFFFF) ? '1 : fine[SCALED_W-1:0];
      end
      return w;
    end
  endfunction

  // offer one word, idling first at the current rate, and wait for acceptance
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        operand.valid <= 1'b0;
        @(negedge clk);
      end
      operand.valid <= 1'b1;
      operand.value <= v;
      do @(posedge clk); while (!operand.ready);
      pending_roots = {pending_roots, predict_root(v)};
      words_sent++;
    end
  endtask

  // drop valid and let every predicted word come back
  task automatic wait_idle();
    begin
      @(negedge clk);
      operand.valid <= 1'b0;
      while (pending_roots.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  // extremes, zero, perfect squares and their neighbours, negatives
  task automatic test_directed();
    begin
      send_value(32'sd0);
      send_value(32'sd1);
      send_value(32'sd2);
      send_value(32'sd3);
      send_value(32'sd4);
      send_value(32'sd99);
      send_value(32'sd100);
      send_value(32'sd65535);
      send_value(32'sd65536);
      send_value(32'sd2147395599);  // one below 46340 squared
      send_value(32'sd2147395600);  // 46340 squared
      send_value(32'sd2147395601);
      send_value(32'sh7FFFFFFF);    // largest positive
      send_value(32'sh40000000);
      send_value(32'sh55555555);
      send_value(32'sh2AAAAAAA);
      send_value(32'sh00FFFFFF);
      send_value(-32'sd1);
      send_value(32'sh80000000);    // most negative
      send_value(32'shAAAAAAAA);
      send_value(32'shFFFF0000);
      wait_idle();
    end
  endtask

  // random mix: negatives, near perfect squares, small and unrestricted values
  task automatic test_random(input int count, input int idle_pct, input int stall);
    logic signed [VALUE_W-1:0] v;
    int unsigned               r;
    int                        n;
    begin
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (n = 0; n < count; n++) begin
        case ($urandom_range(3))
          0: v = {1'b1, 31'($urandom)};
          1: begin
            r = $urandom_range(46340);
            v = $signed(r * r) + $signed($urandom_range(2)) - 32'sd1;
          end
          2: v = $urandom_range(1000);
          default: v = $urandom;
        endcase
        send_value(v);
      end
      wait_idle();
    end
  endtask

  // receiver holds off long enough for the row to fill and the input to stall
  task automatic test_backpressure();
    int n;
    begin
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests++;
      for (n = 0; n < 60; n++) send_value($urandom);
      wait_idle();
    end
  endtask

  // receiver side: random stall, or a counted hold-off when one is asked for
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin
    root_word_t want;
    if (!rst && operand.valid && !operand.ready) input_stalls++;
    if (!rst && result.valid && result.ready) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected: int %0d scaled %0d neg %0b",
                 $time, result.integer_root, result.scaled_root, result.negative_input);
      end else begin
        want = pending_roots.pop_front();
        roots_checked++;
        if (result.integer_root !== want.integer_root ||
            result.scaled_root !== want.scaled_root ||
            result.negative_input !== want.negative_input) begin
          mismatches++;
          $display("%0t: mismatch expected int %0d scaled %0d neg %0b, got int %0d scaled %0d neg %0b",
                   $time, want.integer_root, want.scaled_root, want.negative_input,
                   result.integer_root, result.scaled_root, result.negative_input);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, pending_roots.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    operand.valid = 1'b0;
    operand.value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(150, 0, 0);     // full rate both sides
    test_random(100, 56, 0);    // sender idling
    test_random(100, 0, 56);    // receiver stalling
    test_random(150, 22, 22);   // both
    test_backpressure();

    $display("run covered %0d words: extremes, negatives, squares and neighbours, random mixes",
             words_sent);
    $display("%0d results checked, operand held off %0d cycles, %0d mismatches",
             roots_checked, input_stalls, mismatches);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### decimal_fixed_point_square_root_unit.f
hw/rtl/dfsr_pkg.sv
hw/rtl/dfsr_in_if.sv
hw/rtl/dfsr_out_if.sv
hw/rtl/dfsr_cell.sv
hw/rtl/decimal_fixed_point_square_root_unit.sv
tb/tb_decimal_fixed_point_square_root_unit.sv
